// File: rtl/ctnms_pkg.sv
// Package for the corner threshold and 3x3 non-maximum suppression core.
// Holds sizes, register codes, reset values and shared types.
// Depends on nothing; every module of the core imports it.
package ctnms_pkg;

    // Frame and pixel sizes.
    localparam int WIDTH_LIMIT  = 2048;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int RESP_BITS    = 16;
    localparam int FRAC_BITS    = 8;
    localparam int INT_BITS     = RESP_BITS - FRAC_BITS;

    localparam int COL_W  = $clog2(WIDTH_LIMIT);
    localparam int ROW_W  = $clog2(HEIGHT_LIMIT);
    localparam int SIZE_W = ROW_W + 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 13;
    localparam int THR_W      = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_THRESHOLD    = 2'd2
    } cfg_reg_t;

    // Reset values, kept as last column and last row indexes.
    localparam logic [COL_W-1:0] RESET_COL_LAST  = COL_W'(640 - 1);
    localparam logic [ROW_W-1:0] RESET_ROW_LAST  = ROW_W'(480 - 1);
    localparam logic [THR_W-1:0] RESET_THRESHOLD = THR_W'(128);

    typedef logic [RESP_BITS-1:0] resp_t;
    typedef logic [COL_W-1:0]     col_t;
    typedef logic [ROW_W-1:0]     row_t;

    // Keypoint candidates of one window, in raster order.
    typedef struct packed {
        logic corner;   // bottom-right center, last row and last column
        logic below;    // center on the last row
        logic right;    // center in the last column
        logic center;   // ordinary center, one row and one column back
    } hits_t;

endpackage

// File: rtl/corner_threshold_nms_3x3_core.sv
// Top level of the corner threshold and 3x3 non-maximum suppression core.
// Holds the line memory, the pixel counters, the 3x3 window and the result buffer.
// Depends on ctnms_pkg and ctnms_nms.
//
//  Channel  Handshake             Payload
//  pix      pix_valid/pix_stall   response
//  key      key_valid/key_stall   key_x, key_y, key_response, last
//  cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One pixel per clock is taken unless pix_stall is high; a keypoint is offered after its
// last pixel passes stages 1 and 2. A pixel completing up to four keypoints (end of row,
// last row) holds the input while the buffer drains one keypoint per cycle unless stalled.
// The line memory has one read and one write port; a write-to-read forward covers
// one-pixel rows. Reset clears the counters and pipeline valids and loads the defaults.
// A key_stall backs up through the pipeline into pix_stall in the same cycle.
module corner_threshold_nms_3x3_core
    import ctnms_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pix_valid,
    output logic                   pix_stall,
    input  logic [RESP_BITS-1:0]   response,
    output logic                   key_valid,
    input  logic                   key_stall,
    output logic [COL_W-1:0]       key_x,
    output logic [ROW_W-1:0]       key_y,
    output logic [RESP_BITS-1:0]   key_response,
    output logic                   last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration, kept as last indexes.
    col_t              col_last_reg, col_last_next;
    row_t              row_last_reg, row_last_next;
    logic [THR_W-1:0]  thr_reg, thr_next;
    logic              cfg_take;
    logic [SIZE_W-1:0] size_val;

    // Counters of the next pixel.
    col_t col_cnt_reg, col_cnt_next;
    row_t row_cnt_reg, row_cnt_next;

    // Line memory: each entry holds {middle line, upper line}.
    logic [2*RESP_BITS-1:0] line_mem [WIDTH_LIMIT];
    logic [2*RESP_BITS-1:0] rd_reg;
    logic [2*RESP_BITS-1:0] fwd_data_reg;
    logic                   fwd_reg;
    logic [2*RESP_BITS-1:0] line_word;

    // Stage 1: pixel waiting for its line data.
    logic  s1_valid_reg;
    col_t  s1_col_reg;
    row_t  s1_row_reg;
    resp_t s1_pix_reg;

    // Stage 2: window complete, being evaluated.
    logic  s2_valid_reg;
    col_t  s2_col_reg;
    row_t  s2_row_reg;
    resp_t win_reg  [9];
    resp_t win_next [9];
    hits_t hits;

    // Stage 3: result buffer drained one keypoint per transaction.
    logic [3:0] pend_reg, pend_next;
    col_t       s3_col_reg;
    row_t       s3_row_reg;
    resp_t      s3_val_reg [4];
    logic [3:0] low_bit;
    logic [1:0] slot;

    // Handshake and flow control.
    logic pix_take;
    logic key_take;
    logic s3_free;
    logic s2_free;
    logic s2_adv;
    logic s1_adv;
    logic s1_free;

    always_comb
    begin
        low_bit  = pend_reg & (~pend_reg + 4'd1);
        key_take = key_valid && !key_stall;
        s3_free  = (pend_reg == 4'd0) || (key_take && ((pend_reg & ~low_bit) == 4'd0));
        s2_adv   = s2_valid_reg && s3_free;
        s2_free  = !s2_valid_reg || s3_free;
        s1_adv   = s1_valid_reg && s2_free;
        s1_free  = !s1_valid_reg || s2_free;
        pix_stall = !s1_free;
        pix_take  = pix_valid && s1_free;
    end

    // Configuration decode; sizes are clamped to 1..maximum.
    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;

    always_comb
    begin
        col_last_next = col_last_reg;
        row_last_next = row_last_reg;
        thr_next      = thr_reg;
        size_val      = '0;
        if (cfg_take)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    size_val = SIZE_W'(cfg_data[WIDTH_W-1:0]);
                    if (size_val == '0)
                        col_last_next = '0;
                    else if (size_val > SIZE_W'(WIDTH_LIMIT))
                        col_last_next = COL_W'(WIDTH_LIMIT - 1);
                    else
                        col_last_next = COL_W'(size_val - SIZE_W'(1));
                end
                REG_IMAGE_HEIGHT:
                begin
                    size_val = SIZE_W'(cfg_data[HEIGHT_W-1:0]);
                    if (size_val == '0)
                        row_last_next = '0;
                    else if (size_val > SIZE_W'(HEIGHT_LIMIT))
                        row_last_next = ROW_W'(HEIGHT_LIMIT - 1);
                    else
                        row_last_next = ROW_W'(size_val - SIZE_W'(1));
                end
                REG_THRESHOLD:
                begin
                    thr_next = cfg_data[THR_W-1:0];
                end
                default:
                begin
                    size_val = '0;
                end
            endcase
        end
    end

    // Raster counters; a write to the width, height or threshold register restarts the frame.
    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (cfg_take && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT ||
                         cfg_index == REG_THRESHOLD))
        begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
        else if (pix_take)
        begin
            if (col_cnt_reg == col_last_reg)
            begin
                col_cnt_next = '0;
                row_cnt_next = (row_cnt_reg == row_last_reg) ? '0 : row_cnt_reg + row_t'(1);
            end
            else
            begin
                col_cnt_next = col_cnt_reg + col_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_last_reg <= RESET_COL_LAST;
            row_last_reg <= RESET_ROW_LAST;
            thr_reg      <= RESET_THRESHOLD;
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
        end
        else
        begin
            col_last_reg <= col_last_next;
            row_last_reg <= row_last_next;
            thr_reg      <= thr_next;
            col_cnt_reg  <= col_cnt_next;
            row_cnt_reg  <= row_cnt_next;
        end
    end

    // Line data for stage 1, forwarded when the previous pixel wrote the same column.
    assign line_word = fwd_reg ? fwd_data_reg : rd_reg;

    // Line memory: read on accept, write back {new pixel, old middle} as stage 1 moves on.
    always_ff @(posedge clk)
    begin
        if (pix_take)
        begin
            rd_reg       <= line_mem[col_cnt_reg];
            fwd_data_reg <= {s1_pix_reg, line_word[2*RESP_BITS-1:RESP_BITS]};
        end
        if (s1_adv)
        begin
            line_mem[s1_col_reg] <= {s1_pix_reg, line_word[2*RESP_BITS-1:RESP_BITS]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (pix_take)
        begin
            fwd_reg <= s1_adv && (s1_col_reg == col_cnt_reg);
        end
    end

    // Window shift: old columns move left, the new column is upper, middle, pixel.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i*3 + 0] = win_reg[i*3 + 1];
            win_next[i*3 + 1] = win_reg[i*3 + 2];
        end
        win_next[2] = line_word[RESP_BITS-1:0];
        win_next[5] = line_word[2*RESP_BITS-1:RESP_BITS];
        win_next[8] = s1_pix_reg;
    end

    // Pipeline valids.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            pend_reg     <= '0;
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= pix_take;
            if (s2_free)
                s2_valid_reg <= s1_adv;
            if (s1_adv)
                win_reg <= win_next;
            pend_reg <= pend_next;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (pix_take)
        begin
            s1_col_reg <= col_cnt_reg;
            s1_row_reg <= row_cnt_reg;
            s1_pix_reg <= response;
        end
        if (s1_adv)
        begin
            s2_col_reg <= s1_col_reg;
            s2_row_reg <= s1_row_reg;
        end
        if (s2_adv)
        begin
            s3_col_reg    <= s2_col_reg;
            s3_row_reg    <= s2_row_reg;
            s3_val_reg[0] <= win_reg[4];
            s3_val_reg[1] <= win_reg[5];
            s3_val_reg[2] <= win_reg[7];
            s3_val_reg[3] <= win_reg[8];
        end
    end

    // Candidate evaluation of the stage 2 window.
    ctnms_nms u_nms (
        .win       (win_reg),
        .col       (s2_col_reg),
        .row       (s2_row_reg),
        .col_last  (col_last_reg),
        .row_last  (row_last_reg),
        .threshold (thr_reg),
        .hits      (hits)
    );

    // Result buffer: load a new set of hits or retire the lowest pending one.
    always_comb
    begin
        pend_next = pend_reg;
        if (s2_adv)
            pend_next = hits;
        else if (key_take)
            pend_next = pend_reg & ~low_bit;
    end

    // Select the first pending keypoint.
    always_comb
    begin
        case (low_bit)
            4'b0010: slot = 2'd1;
            4'b0100: slot = 2'd2;
            4'b1000: slot = 2'd3;
            default: slot = 2'd0;
        endcase
    end

    assign key_valid    = (pend_reg != 4'd0);
    assign key_x        = slot[0] ? s3_col_reg : s3_col_reg - col_t'(1);
    assign key_y        = slot[1] ? s3_row_reg : s3_row_reg - row_t'(1);
    assign key_response = s3_val_reg[slot];
    assign last         = ((pend_reg & ~low_bit) == 4'd0);

endmodule

// File: rtl/ctnms_nms.sv
// Threshold and 3x3 non-maximum suppression of the current window.
// Evaluates the four possible centers of one window in parallel.
// Depends on ctnms_pkg.
module ctnms_nms
    import ctnms_pkg::*;
(
    input  resp_t             win [9],
    input  col_t              col,
    input  row_t              row,
    input  col_t              col_last,
    input  row_t              row_last,
    input  logic [THR_W-1:0]  threshold,
    output hits_t             hits
);

    // Window row and column of each of the four candidate centers.
    localparam logic [1:0] CEN_I [4] = '{2'd1, 2'd1, 2'd2, 2'd2};
    localparam logic [1:0] CEN_J [4] = '{2'd1, 2'd2, 2'd1, 2'd2};

    logic [2:0] row_ok;
    logic [2:0] col_ok;
    logic [3:0] peak;

    // Window cells left of column 0 or above row 0 are ignored.
    always_comb
    begin
        row_ok = {1'b1, (row != '0), (row > row_t'(1))};
        col_ok = {1'b1, (col != '0), (col > col_t'(1))};
    end

    // Each candidate must clear the threshold and not be beaten by an in-image neighbor.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            peak[k] = row_ok[CEN_I[k]] && col_ok[CEN_J[k]] &&
                      (win[CEN_I[k]*3 + CEN_J[k]][RESP_BITS-1:FRAC_BITS] > threshold);
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    if (((i + 1) >= CEN_I[k]) && (i <= (CEN_I[k] + 1)) &&
                        ((j + 1) >= CEN_J[k]) && (j <= (CEN_J[k] + 1)) &&
                        row_ok[i] && col_ok[j] &&
                        (win[i*3 + j] > win[CEN_I[k]*3 + CEN_J[k]]))
                    begin
                        peak[k] = 1'b0;
                    end
                end
            end
        end
    end

    // Edge centers only complete at the end of a row or on the last row.
    always_comb
    begin
        hits.center = peak[0];
        hits.right  = peak[1] && (col == col_last);
        hits.below  = peak[2] && (row == row_last);
        hits.corner = peak[3] && (col == col_last) && (row == row_last);
    end

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for corner_threshold_nms_3x3_core: threshold and 3x3 peak picking.
// A queue-fed pixel driver, a keypoint checker and a configuration writer run against
// a keypoint predictor kept in this file. Depends on ctnms_pkg and the core RTL.
module tb;
    import ctnms_pkg::*;

    // Index with no register behind it; a write there must leave the frame alone.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 120;
    localparam int RANDOM_ITEMS  = 110;
    localparam int EDGE_PIXELS   = 8;

    typedef struct packed {
        bit [COL_W-1:0]     x;
        bit [ROW_W-1:0]     y;
        bit [RESP_BITS-1:0] resp;
        bit                 last;
    } keypoint_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  pix_valid = 1'b0;
    logic                  pix_stall;
    logic [RESP_BITS-1:0]  response = '0;
    logic                  key_valid;
    logic                  key_stall = 1'b0;
    logic [COL_W-1:0]      key_x;
    logic [ROW_W-1:0]      key_y;
    logic [RESP_BITS-1:0]  key_response;
    logic                  key_last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Pixels waiting to be offered and keypoints waiting to come out.
    bit [RESP_BITS-1:0] pending_pixels[$];
    keypoint_t          expected_keys[$];
    keypoint_t          next_key;

    // Predictor state: line stores, 3x3 neighborhood, raster position, registers.
    bit [RESP_BITS-1:0] upper_row [WIDTH_LIMIT];
    bit [RESP_BITS-1:0] middle_row [WIDTH_LIMIT];
    bit [RESP_BITS-1:0] win_cells [9];
    int                 col_pos = 0;
    int                 row_pos = 0;
    bit [WIDTH_W-1:0]   width_reg = 640;
    bit [HEIGHT_W-1:0]  height_reg = 480;
    bit [THR_W-1:0]     thr_reg = 128;

    // Traffic shaping and bookkeeping.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_taken = 0;
    int hold_left = 0;
    int errors = 0;
    int pixels_sent = 0;
    int keys_checked = 0;
    int keys_predicted = 0;
    int config_writes = 0;
    int random_items = 0;

    corner_threshold_nms_3x3_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_valid    (pix_valid),
        .pix_stall    (pix_stall),
        .response     (response),
        .key_valid    (key_valid),
        .key_stall    (key_stall),
        .key_x        (key_x),
        .key_y        (key_y),
        .key_response (key_response),
        .last         (key_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Test the neighborhood cell (ci, cj) as a keypoint center. Cells left of column 0
    // or above row 0 are outside the image and neither qualify nor suppress.
    function automatic bit keypoint_at(input int ci, input int cj, input int c, input int r,
                                       output keypoint_t kp);
        int cx;
        int cy;
        int i;
        int j;
        bit [RESP_BITS-1:0] v;
        cx = c - 2 + cj;
        cy = r - 2 + ci;
        v  = win_cells[ci * 3 + cj];
        kp = '0;
        if (cx < 0 || cy < 0)
            return 1'b0;
        if ((v >> FRAC_BITS) <= thr_reg)
            return 1'b0;
        for (i = ci - 1; i <= ci + 1; i++)
            for (j = cj - 1; j <= cj + 1; j++)
                if (i <= 2 && j <= 2 && r - 2 + i >= 0 && c - 2 + j >= 0
                    && win_cells[i * 3 + j] > v)
                    return 1'b0;
        kp.x    = COL_W'(cx);
        kp.y    = ROW_W'(cy);
        kp.resp = v;
        return 1'b1;
    endfunction

    // Advance the predictor by one pixel and queue the keypoints it completes.
    task automatic predict_keypoints(input bit [RESP_BITS-1:0] pix);
        int w;
        int h;
        int c;
        int r;
        int i;
        bit [RESP_BITS-1:0] up;
        bit [RESP_BITS-1:0] mid;
        keypoint_t kp;
        keypoint_t found[$];
        w = (width_reg == 0) ? 1 :
            ((width_reg > WIDTH_LIMIT) ? WIDTH_LIMIT : int'(width_reg));
        h = (height_reg == 0) ? 1 :
            ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(height_reg));
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;

        up  = upper_row[c];
        mid = middle_row[c];
        upper_row[c]  = mid;
        middle_row[c] = pix;
        for (i = 0; i < 3; i++)
        begin
            win_cells[i * 3]     = win_cells[i * 3 + 1];
            win_cells[i * 3 + 1] = win_cells[i * 3 + 2];
        end
        win_cells[2] = up;
        win_cells[5] = mid;
        win_cells[8] = pix;

        // Raster order: center, end of row, then the last-row centers.
        if (keypoint_at(1, 1, c, r, kp))
            found = {found, kp};
        if (c == w - 1 && keypoint_at(1, 2, c, r, kp))
            found = {found, kp};
        if (r == h - 1)
        begin
            if (keypoint_at(2, 1, c, r, kp))
                found = {found, kp};
            if (c == w - 1 && keypoint_at(2, 2, c, r, kp))
                found = {found, kp};
        end
        if (found.size() != 0)
            found[found.size() - 1].last = 1'b1;
        foreach (found[k])
            expected_keys = {expected_keys, found[k]};
        keys_predicted += found.size();

        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    // Pixel driver: predicts on each accepted transaction, then offers the next pixel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_valid && !pix_stall)
            begin
                predict_keypoints(response);
                pixels_sent++;
            end
            if (!pix_valid || !pix_stall)
            begin
                if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    pix_valid <= 1'b1;
                    response  <= pending_pixels.pop_front();
                end
                else
                    pix_valid <= 1'b0;
            end
        end
    end

    // Keypoint receiver stall: random back-pressure, or a long hold when one is requested.
    always @(posedge clk)
    begin
        if (!rst_n)
            key_stall <= 1'b0;
        else if (hold_taken != hold_requests)
        begin
            hold_taken <= hold_requests;
            hold_left  <= HOLD_CYCLES;
            key_stall  <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            key_stall <= 1'b1;
        end
        else
            key_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Keypoint checker: each accepted transaction against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && key_valid && !key_stall)
        begin
            if (expected_keys.size() == 0)
            begin
                $error("unexpected keypoint at x=%0d y=%0d", key_x, key_y);
                errors++;
            end
            else
            begin
                next_key = expected_keys.pop_front();
                if (key_x !== next_key.x)
                begin
                    $error("key_x: expected %0d, got %0d", next_key.x, key_x);
                    errors++;
                end
                if (key_y !== next_key.y)
                begin
                    $error("key_y: expected %0d, got %0d", next_key.y, key_y);
                    errors++;
                end
                if (key_response !== next_key.resp)
                begin
                    $error("key_response: expected 0x%04h, got 0x%04h", next_key.resp,
                           key_response);
                    errors++;
                end
                if (key_last !== next_key.last)
                begin
                    $error("last: expected %0d, got %0d", next_key.last, key_last);
                    errors++;
                end
                keys_checked++;
            end
        end
    end

    // Wait until every pixel is in and every keypoint out, then let the pipeline settle.
    task automatic wait_quiet();
        while (pending_pixels.size() != 0 || pix_valid || expected_keys.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One configuration transaction; the predictor takes the same write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        config_writes++;
        case (idx)
            REG_IMAGE_WIDTH:  width_reg  = data[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: height_reg = data[HEIGHT_W-1:0];
            REG_THRESHOLD:    thr_reg    = data[THR_W-1:0];
            default:          ;
        endcase
        if (idx != REG_UNUSED)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        @(negedge clk);
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] w_data,
                             input logic [CFG_DATA_W-1:0] h_data,
                             input logic [CFG_DATA_W-1:0] thr_data);
        wait_quiet();
        write_register(REG_IMAGE_WIDTH, w_data);
        write_register(REG_IMAGE_HEIGHT, h_data);
        write_register(REG_THRESHOLD, thr_data);
    endtask

    // One random frame shape, then one or two frames of pixels, sometimes cut short.
    task automatic run_random_frame();
        int w;
        int h;
        int n;
        bit [RESP_BITS-1:0] tie;
        bit [RESP_BITS-1:0] v;
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 6);
        set_frame((CFG_DATA_W'($urandom_range(0, 1)) << WIDTH_W) | CFG_DATA_W'(w),
                  CFG_DATA_W'(h),
                  (CFG_DATA_W'($urandom_range(0, 31)) << THR_W) |
                  CFG_DATA_W'($urandom_range(0, 230)));
        if ($urandom_range(0, 5) == 0)
            write_register(REG_UNUSED, CFG_DATA_W'($urandom));
        n = w * h * $urandom_range(1, 2);
        if ($urandom_range(0, 4) == 0)
            n = $urandom_range(1, n);
        if (n > RANDOM_ITEMS - random_items)
            n = RANDOM_ITEMS - random_items;
        tie = RESP_BITS'($urandom);
        repeat (n)
        begin
            case ($urandom_range(0, 3))
                0:       v = RESP_BITS'($urandom);
                1:       v = tie;
                2:       v = RESP_BITS'($urandom_range(0, 255));
                default: v = RESP_BITS'($urandom_range(16'hC000, 16'hFFFF));
            endcase
            pending_pixels = {pending_pixels, v};
        end
        random_items += n;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: a 3x3 frame with ties, extremes and a zero threshold.
        send_idle_pct = 34;
        recv_idle_pct = 81;
        set_frame(3, 3, 13'h1F00);
        pending_pixels = '{16'h0000, 16'hFFFF, 16'hFFFF,
                           16'h0100, 16'h0080, 16'h0200,
                           16'h0300, 16'h0300, 16'h0001};

        // Zero sizes act as one pixel; threshold sits just under and at the top.
        wait_quiet();
        write_register(REG_UNUSED, 13'h1FFF);
        set_frame(13'h1000, 0, 13'h00FE);
        pending_pixels = '{16'hFF00, 16'hFEFF, 16'hFFFF};
        set_frame(1, 1, 13'h00FF);
        pending_pixels = '{16'hFFFF, 16'hFF00};

        // A write to the unused index in mid-frame must not restart the frame.
        set_frame(2, 2, 0);
        pending_pixels = '{16'h0500, 16'h0400};
        wait_quiet();
        write_register(REG_UNUSED, 0);
        pending_pixels = '{16'h0600, 16'h0500};

        // Random frames over the three traffic profiles.
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items < 37)
            begin
                send_idle_pct = 34;
                recv_idle_pct = 81;
            end
            else if (random_items < 74)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 34;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_random_frame();
        end

        // Flat frame where every pixel is a keypoint, with the receiver held off.
        set_frame(4, 4, 0);
        repeat (16) pending_pixels = {pending_pixels, 16'h0100};
        hold_requests = hold_requests + 1;

        // Start of the widest row, clamped from an oversize width, and of the tallest column.
        set_frame(13'h0FFF, 1, 13'h1F7F);
        repeat (EDGE_PIXELS - 1)
            pending_pixels = {pending_pixels,
                              (($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000)};
        pending_pixels = {pending_pixels, 16'hFFFF};
        set_frame(0, 13'h1FFF, 200);
        repeat (EDGE_PIXELS - 1)
            pending_pixels = {pending_pixels,
                              (($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000)};
        pending_pixels = {pending_pixels, 16'hFFFF};

        wait_quiet();
        $display("Covered %0d pixels over %0d configuration writes, including oversize frames;",
                 pixels_sent, config_writes);
        $display("%0d keypoints predicted, %0d compared, %0d mismatches.",
                 keys_predicted, keys_checked, errors);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #20000000;
        $display("tb failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/ctnms_pkg.sv
rtl/ctnms_nms.sv
rtl/corner_threshold_nms_3x3_core.sv
tb/sv/tb.sv
